FILE: rtl/bcd_clock_with_alarm_defines.svh
// ----------------------------------------------------------------------------
// BCD clock with alarm: assertion macros
// Concurrent assertion helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BCD_CLOCK_WITH_ALARM_DEFINES_SVH
`define BCD_CLOCK_WITH_ALARM_DEFINES_SVH

`ifndef SYNTH
`define BCWA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BCWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BCWA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BCWA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/bcwa_pkg.sv
// ----------------------------------------------------------------------------
// BCD clock with alarm: package
// Operation codes, digit limits and the item, time and result types.
// ----------------------------------------------------------------------------
package bcwa_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET_TIME  = 3'd1,
    OP_SET_ALARM = 3'd2,
    OP_ALARM_EN  = 3'd3,
    OP_SNOOZE    = 3'd4,
    OP_ACK       = 3'd5,
    OP_READ      = 3'd6
  } op_e;

  localparam logic [3:0]  UNITS_MAX      = 4'd9;
  localparam logic [3:0]  TENS_MAX       = 4'd5;
  localparam logic [3:0]  HOUR_TENS_MAX  = 4'd2;
  localparam logic [3:0]  HOUR_UNITS_TOP = 4'd3;
  localparam logic [31:0] TPS_RESET      = 32'd1000;

  typedef struct packed {
    logic [1:0] ht;
    logic [3:0] hu;
    logic [2:0] mt;
    logic [3:0] mu;
    logic [2:0] st;
    logic [3:0] su;
  } time_t;

  typedef struct packed {
    time_t next;
    logic  minute_step;
  } step_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] hour_tens;
    logic [3:0] hour_units;
    logic [3:0] minute_tens;
    logic [3:0] minute_units;
    logic [3:0] second_tens;
    logic [3:0] second_units;
    logic       enable_flag;
    logic [7:0] snooze_minutes;
  } item_t;

  typedef struct packed {
    time_t cur;
    logic  time_is_valid;
    logic  alarm_is_enabled;
    logic  alarm_ringing;
    logic  accepted;
  } result_t;

endpackage

FILE: rtl/bcwa_in_if.sv
// ----------------------------------------------------------------------------
// BCD clock with alarm: input channel
// Valid/ready channel carrying one operation and its operands.
// ----------------------------------------------------------------------------
interface bcwa_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [3:0] hour_tens;
  logic [3:0] hour_units;
  logic [3:0] minute_tens;
  logic [3:0] minute_units;
  logic [3:0] second_tens;
  logic [3:0] second_units;
  logic       enable_flag;
  logic [7:0] snooze_minutes;

  modport source (
    output valid, operation, hour_tens, hour_units, minute_tens, minute_units,
           second_tens, second_units, enable_flag, snooze_minutes,
    input  ready
  );

  modport sink (
    input  valid, operation, hour_tens, hour_units, minute_tens, minute_units,
           second_tens, second_units, enable_flag, snooze_minutes,
    output ready
  );
endinterface

FILE: rtl/bcwa_out_if.sv
// ----------------------------------------------------------------------------
// BCD clock with alarm: result channel
// Valid/ready channel carrying the clock status after one transaction.
// ----------------------------------------------------------------------------
interface bcwa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cur_hour_tens;
  logic [3:0] cur_hour_units;
  logic [2:0] cur_minute_tens;
  logic [3:0] cur_minute_units;
  logic [2:0] cur_second_tens;
  logic [3:0] cur_second_units;
  logic       time_is_valid;
  logic       alarm_is_enabled;
  logic       alarm_ringing;
  logic       accepted;

  modport source (
    output valid, cur_hour_tens, cur_hour_units, cur_minute_tens, cur_minute_units,
           cur_second_tens, cur_second_units, time_is_valid, alarm_is_enabled,
           alarm_ringing, accepted,
    input  ready
  );

  modport sink (
    input  valid, cur_hour_tens, cur_hour_units, cur_minute_tens, cur_minute_units,
           cur_second_tens, cur_second_units, time_is_valid, alarm_is_enabled,
           alarm_ringing, accepted,
    output ready
  );
endinterface

FILE: rtl/bcd_clock_with_alarm.sv
// ----------------------------------------------------------------------------
// BCD clock with alarm: top level
// 24-hour BCD clock with tick prescaler, alarm latch and snooze countdown.
// ----------------------------------------------------------------------------
// Each transaction on in_i yields exactly one result on out_o, in order. The
// block takes one transaction per cycle while out_o is not stalled: an input
// register feeds a single pass of BCD carry, prescaler compare and alarm
// compare logic that writes the result register, which drives out_o. Write
// ticks_per_second through cfg_we_i and cfg_data_i only while no transaction
// is in flight; it resets to 1000.
`include "bcd_clock_with_alarm_defines.svh"

module bcd_clock_with_alarm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  bcwa_in_if.sink     in_i,
  bcwa_out_if.source  out_o
);

  bcwa_pkg::item_t   in_q;
  bcwa_pkg::result_t res_d, res_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;
  logic [31:0]       tps_q;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tps_q       <= bcwa_pkg::TPS_RESET;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        tps_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= '{operation:      in_i.operation,
                hour_tens:      in_i.hour_tens,
                hour_units:     in_i.hour_units,
                minute_tens:    in_i.minute_tens,
                minute_units:   in_i.minute_units,
                second_tens:    in_i.second_tens,
                second_units:   in_i.second_units,
                enable_flag:    in_i.enable_flag,
                snooze_minutes: in_i.snooze_minutes};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  bcwa_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (advance),
    .item_i   (in_q),
    .tps_i    (tps_q),
    .result_o (res_d)
  );

  assign out_o.valid            = out_valid_q;
  assign out_o.cur_hour_tens    = res_q.cur.ht;
  assign out_o.cur_hour_units   = res_q.cur.hu;
  assign out_o.cur_minute_tens  = res_q.cur.mt;
  assign out_o.cur_minute_units = res_q.cur.mu;
  assign out_o.cur_second_tens  = res_q.cur.st;
  assign out_o.cur_second_units = res_q.cur.su;
  assign out_o.time_is_valid    = res_q.time_is_valid;
  assign out_o.alarm_is_enabled = res_q.alarm_is_enabled;
  assign out_o.alarm_ringing    = res_q.alarm_ringing;
  assign out_o.accepted         = res_q.accepted;

  `BCWA_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q)
  `BCWA_ASSERT_NEXT(a_stalled_item_kept, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)
  `BCWA_ASSERT_SAME(a_hour_in_range, clk_i, rst_ni, out_valid_q,
                    (res_q.cur.ht != 2'd3) && ((res_q.cur.ht != 2'd2) || (res_q.cur.hu <= 4'd3)))

endmodule

FILE: rtl/bcwa_time_step.sv
// ----------------------------------------------------------------------------
// BCD clock with alarm: one-second step
// Advances HH:MM:SS by one second with BCD carries and 24-hour wrap.
// ----------------------------------------------------------------------------
module bcwa_time_step (
  input  bcwa_pkg::time_t time_i,
  output bcwa_pkg::step_t step_o
);

  always_comb begin
    step_o.next        = time_i;
    step_o.minute_step = 1'b0;
    if (time_i.su < bcwa_pkg::UNITS_MAX) begin
      step_o.next.su = time_i.su + 4'd1;
    end else begin
      step_o.next.su = '0;
      if ({1'b0, time_i.st} < bcwa_pkg::TENS_MAX) begin
        step_o.next.st = time_i.st + 3'd1;
      end else begin
        step_o.next.st     = '0;
        step_o.minute_step = 1'b1;
        if (time_i.mu < bcwa_pkg::UNITS_MAX) begin
          step_o.next.mu = time_i.mu + 4'd1;
        end else begin
          step_o.next.mu = '0;
          if ({1'b0, time_i.mt} < bcwa_pkg::TENS_MAX) begin
            step_o.next.mt = time_i.mt + 3'd1;
          end else begin
            step_o.next.mt = '0;
            if ({2'b00, time_i.ht} < bcwa_pkg::HOUR_TENS_MAX) begin
              if (time_i.hu < bcwa_pkg::UNITS_MAX) begin
                step_o.next.hu = time_i.hu + 4'd1;
              end else begin
                step_o.next.hu = '0;
                step_o.next.ht = time_i.ht + 2'd1;
              end
            end else if (time_i.hu < bcwa_pkg::HOUR_UNITS_TOP) begin
              step_o.next.hu = time_i.hu + 4'd1;
            end else begin
              step_o.next.hu = '0;
              step_o.next.ht = '0;
            end
          end
        end
      end
    end
  end

endmodule

FILE: rtl/bcwa_core.sv
// ----------------------------------------------------------------------------
// BCD clock with alarm: clock state
// Holds time, alarm, snooze and prescaler; applies one operation per cycle when take_i is set.
// ----------------------------------------------------------------------------
module bcwa_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  bcwa_pkg::item_t   item_i,
  input  logic [31:0]       tps_i,
  output bcwa_pkg::result_t result_o
);

  bcwa_pkg::time_t time_q, time_d;
  bcwa_pkg::time_t alarm_q, alarm_d;
  bcwa_pkg::time_t set_time;
  bcwa_pkg::step_t step;
  logic            valid_q, valid_d;
  logic            en_q, en_d;
  logic            latch_q, latch_d;
  logic [7:0]      snooze_q, snooze_d;
  logic [31:0]     tick_q, tick_d;
  logic [31:0]     tick_inc;
  logic            digits_ok;
  logic            accepted;

  bcwa_time_step u_step (
    .time_i (time_q),
    .step_o (step)
  );

  always_comb begin
    digits_ok = (item_i.second_units <= bcwa_pkg::UNITS_MAX) &&
                (item_i.second_tens  <= bcwa_pkg::TENS_MAX) &&
                (item_i.minute_units <= bcwa_pkg::UNITS_MAX) &&
                (item_i.minute_tens  <= bcwa_pkg::TENS_MAX);
    if (item_i.hour_tens < bcwa_pkg::HOUR_TENS_MAX) begin
      digits_ok = digits_ok && (item_i.hour_units <= bcwa_pkg::UNITS_MAX);
    end else if (item_i.hour_tens == bcwa_pkg::HOUR_TENS_MAX) begin
      digits_ok = digits_ok && (item_i.hour_units <= bcwa_pkg::HOUR_UNITS_TOP);
    end else begin
      digits_ok = 1'b0;
    end
  end

  assign set_time = '{ht: item_i.hour_tens[1:0],   hu: item_i.hour_units,
                      mt: item_i.minute_tens[2:0], mu: item_i.minute_units,
                      st: item_i.second_tens[2:0], su: item_i.second_units};
  assign tick_inc = tick_q + 32'd1;

  always_comb begin
    time_d   = time_q;
    alarm_d  = alarm_q;
    valid_d  = valid_q;
    en_d     = en_q;
    latch_d  = latch_q;
    snooze_d = snooze_q;
    tick_d   = tick_q;
    accepted = 1'b1;
    case (bcwa_pkg::op_e'(item_i.operation))
      bcwa_pkg::OP_TICK: begin
        tick_d = tick_inc;
        if (tick_inc == tps_i) begin
          tick_d = '0;
          time_d = step.next;
          if (step.minute_step && (snooze_q != 8'd0)) begin
            snooze_d = snooze_q - 8'd1;
          end
          if (en_q && (step.next == alarm_q)) begin
            latch_d = 1'b1;
          end
        end
      end
      bcwa_pkg::OP_SET_TIME: begin
        accepted = digits_ok;
        if (digits_ok) begin
          time_d  = set_time;
          valid_d = 1'b1;
        end
      end
      bcwa_pkg::OP_SET_ALARM: begin
        accepted = digits_ok;
        if (digits_ok) begin
          alarm_d = set_time;
          en_d    = 1'b1;
        end
      end
      bcwa_pkg::OP_ALARM_EN: en_d     = item_i.enable_flag;
      bcwa_pkg::OP_SNOOZE:   snooze_d = item_i.snooze_minutes;
      bcwa_pkg::OP_ACK:      latch_d  = 1'b0;
      default: ;
    endcase
  end

  assign result_o = '{cur:              time_d,
                      time_is_valid:    valid_d,
                      alarm_is_enabled: en_d,
                      alarm_ringing:    latch_d && (snooze_d == 8'd0),
                      accepted:         accepted};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      alarm_q  <= '0;
      valid_q  <= 1'b0;
      en_q     <= 1'b0;
      latch_q  <= 1'b0;
      snooze_q <= '0;
      tick_q   <= '0;
    end else if (take_i) begin
      time_q   <= time_d;
      alarm_q  <= alarm_d;
      valid_q  <= valid_d;
      en_q     <= en_d;
      latch_q  <= latch_d;
      snooze_q <= snooze_d;
      tick_q   <= tick_d;
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// BCD clock with alarm: testbench
// Drives operations through the input channel and checks every status
// transaction against a cycle-free model of the clock, prescaler, alarm
// latch and snooze count. Runs directed cases, then random phases with
// varied prescaler settings, idling and output stalls, a long output hold-off, and
// finally the prescaler extremes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         PRINT_LIMIT = 100;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_data;

  bcwa_in_if  in_ch ();
  bcwa_out_if out_ch ();

  bcd_clock_with_alarm dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [0:5][3:0] now_digits;
  logic [0:5][3:0] alarm_digits;
  logic            time_set;
  logic            alarm_on;
  logic            alarm_latch;
  logic [7:0]      snooze_left;
  logic [31:0]     tick_count;
  logic [31:0]     tps;

  bcwa_pkg::result_t status_q[$];
  int      errors = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      ready_stall_pct = 0;
  int      hold_left = 0;

  function automatic bcwa_pkg::result_t clock_after(bcwa_pkg::item_t it);
    logic [0:5][3:0]   d;
    logic              well_formed;
    logic              ok;
    bcwa_pkg::result_t r;
    d = {it.hour_tens, it.hour_units, it.minute_tens, it.minute_units,
         it.second_tens, it.second_units};
    well_formed = d[5] <= bcwa_pkg::UNITS_MAX && d[4] <= bcwa_pkg::TENS_MAX &&
                  d[3] <= bcwa_pkg::UNITS_MAX && d[2] <= bcwa_pkg::TENS_MAX &&
                  (d[0] < bcwa_pkg::HOUR_TENS_MAX ? d[1] <= bcwa_pkg::UNITS_MAX :
                   d[0] == bcwa_pkg::HOUR_TENS_MAX && d[1] <= bcwa_pkg::HOUR_UNITS_TOP);
    ok = 1'b1;
    case (it.operation)
      bcwa_pkg::OP_TICK: begin
        tick_count = tick_count + 32'd1;
        if (tick_count == tps) begin
          tick_count = '0;
          if (now_digits[5] < bcwa_pkg::UNITS_MAX) begin
            now_digits[5] = now_digits[5] + 4'd1;
          end else begin
            now_digits[5] = '0;
            if (now_digits[4] < bcwa_pkg::TENS_MAX) begin
              now_digits[4] = now_digits[4] + 4'd1;
            end else begin
              now_digits[4] = '0;
              if (now_digits[3] < bcwa_pkg::UNITS_MAX) begin
                now_digits[3] = now_digits[3] + 4'd1;
              end else begin
                now_digits[3] = '0;
                if (now_digits[2] < bcwa_pkg::TENS_MAX) begin
                  now_digits[2] = now_digits[2] + 4'd1;
                end else begin
                  now_digits[2] = '0;
                  if (now_digits[0] < bcwa_pkg::HOUR_TENS_MAX) begin
                    if (now_digits[1] < bcwa_pkg::UNITS_MAX) begin
                      now_digits[1] = now_digits[1] + 4'd1;
                    end else begin
                      now_digits[1] = '0;
                      now_digits[0] = now_digits[0] + 4'd1;
                    end
                  end else if (now_digits[1] < bcwa_pkg::HOUR_UNITS_TOP) begin
                    now_digits[1] = now_digits[1] + 4'd1;
                  end else begin
                    now_digits[1] = '0;
                    now_digits[0] = '0;
                  end
                end
              end
              if (snooze_left != 8'd0) snooze_left = snooze_left - 8'd1;
            end
          end
          if (alarm_on && now_digits == alarm_digits) alarm_latch = 1'b1;
        end
      end
      bcwa_pkg::OP_SET_TIME: begin
        if (well_formed) begin
          now_digits = d;
          time_set   = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      bcwa_pkg::OP_SET_ALARM: begin
        if (well_formed) begin
          alarm_digits = d;
          alarm_on     = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      bcwa_pkg::OP_ALARM_EN: alarm_on = it.enable_flag;
      bcwa_pkg::OP_SNOOZE:   snooze_left = it.snooze_minutes;
      bcwa_pkg::OP_ACK:      alarm_latch = 1'b0;
      default: ;
    endcase
    r.cur.ht            = now_digits[0][1:0];
    r.cur.hu            = now_digits[1];
    r.cur.mt            = now_digits[2][2:0];
    r.cur.mu            = now_digits[3];
    r.cur.st            = now_digits[4][2:0];
    r.cur.su            = now_digits[5];
    r.time_is_valid     = time_set;
    r.alarm_is_enabled  = alarm_on;
    r.alarm_ringing     = alarm_latch && snooze_left == 8'd0;
    r.accepted          = ok;
    return r;
  endfunction

  function automatic bcwa_pkg::item_t cmd(logic [2:0] op, logic [23:0] hhmmss = '0,
                                          logic flag = 1'b0, logic [7:0] minutes = '0);
    bcwa_pkg::item_t it;
    it.operation = op;
    {it.hour_tens, it.hour_units, it.minute_tens, it.minute_units,
     it.second_tens, it.second_units} = hhmmss;
    it.enable_flag    = flag;
    it.snooze_minutes = minutes;
    return it;
  endfunction

  function automatic bcwa_pkg::item_t random_item();
    bcwa_pkg::item_t it;
    int              pick;
    it.hour_tens      = 4'($urandom_range(15));
    it.hour_units     = 4'($urandom_range(15));
    it.minute_tens    = 4'($urandom_range(15));
    it.minute_units   = 4'($urandom_range(15));
    it.second_tens    = 4'($urandom_range(15));
    it.second_units   = 4'($urandom_range(15));
    it.enable_flag    = 1'($urandom_range(1));
    it.snooze_minutes = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.operation = bcwa_pkg::OP_TICK;
    end else if (pick < 63) begin
      it.operation = bcwa_pkg::OP_SET_TIME;
      if (pick < 61) begin
        // land just before a minute rollover
        it.hour_tens    = 4'($urandom_range(2));
        it.hour_units   = it.hour_tens == bcwa_pkg::HOUR_TENS_MAX ?
                          4'($urandom_range(3)) : 4'($urandom_range(9));
        it.minute_tens  = 4'($urandom_range(5));
        it.minute_units = $urandom_range(1) ? bcwa_pkg::UNITS_MAX : 4'($urandom_range(9));
        it.second_tens  = bcwa_pkg::TENS_MAX;
        it.second_units = 4'($urandom_range(9));
      end
    end else if (pick < 71) begin
      it.operation = bcwa_pkg::OP_SET_ALARM;
      if (pick < 69) begin
        // aim at a second in the current ten-second window
        {it.hour_tens, it.hour_units, it.minute_tens, it.minute_units,
         it.second_tens} = now_digits[0:4];
        it.second_units = 4'($urandom_range(9));
      end
    end else if (pick < 76) begin
      it.operation = bcwa_pkg::OP_ALARM_EN;
    end else if (pick < 81) begin
      it.operation = bcwa_pkg::OP_SNOOZE;
      if (pick < 79) it.snooze_minutes = 8'($urandom_range(3));
    end else if (pick < 88) begin
      it.operation = bcwa_pkg::OP_ACK;
    end else if (pick < 96) begin
      it.operation = bcwa_pkg::OP_READ;
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(input bcwa_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= it.operation;
    in_ch.hour_tens      <= it.hour_tens;
    in_ch.hour_units     <= it.hour_units;
    in_ch.minute_tens    <= it.minute_tens;
    in_ch.minute_units   <= it.minute_units;
    in_ch.second_tens    <= it.second_tens;
    in_ch.second_units   <= it.second_units;
    in_ch.enable_flag    <= it.enable_flag;
    in_ch.snooze_minutes <= it.snooze_minutes;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_tps(input logic [31:0] value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    tps = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= $urandom_range(99) >= ready_stall_pct;
    end
  end

  always @(posedge clk) begin
    bcwa_pkg::result_t got;
    bcwa_pkg::result_t want;
    if (rst_n && in_ch.valid && in_ch.ready)
      status_q.push_back(clock_after({in_ch.operation, in_ch.hour_tens, in_ch.hour_units,
                                      in_ch.minute_tens, in_ch.minute_units,
                                      in_ch.second_tens, in_ch.second_units,
                                      in_ch.enable_flag, in_ch.snooze_minutes}));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.cur_hour_tens, out_ch.cur_hour_units, out_ch.cur_minute_tens,
             out_ch.cur_minute_units, out_ch.cur_second_tens, out_ch.cur_second_units,
             out_ch.time_is_valid, out_ch.alarm_is_enabled, out_ch.alarm_ringing,
             out_ch.accepted};
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t: unexpected transaction, expected none, got %h", $time, got);
      end else begin
        want = status_q.pop_front();
        check_field("cur_hour_tens", want.cur.ht, got.cur.ht);
        check_field("cur_hour_units", want.cur.hu, got.cur.hu);
        check_field("cur_minute_tens", want.cur.mt, got.cur.mt);
        check_field("cur_minute_units", want.cur.mu, got.cur.mu);
        check_field("cur_second_tens", want.cur.st, got.cur.st);
        check_field("cur_second_units", want.cur.su, got.cur.su);
        check_field("time_is_valid", want.time_is_valid, got.time_is_valid);
        check_field("alarm_is_enabled", want.alarm_is_enabled, got.alarm_is_enabled);
        check_field("alarm_ringing", want.alarm_ringing, got.alarm_ringing);
        check_field("accepted", want.accepted, got.accepted);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(cmd(bcwa_pkg::OP_READ));
    send_item(cmd(OP_UNUSED, 24'hFFFFFF, 1'b1, 8'hFF));
    send_item(cmd(bcwa_pkg::OP_SET_TIME, 24'hFFFFFF, 1'b1, 8'hFF));
    send_item(cmd(bcwa_pkg::OP_SET_TIME, 24'h240000));
    send_item(cmd(bcwa_pkg::OP_SET_TIME, 24'h300000));
    send_item(cmd(bcwa_pkg::OP_SET_TIME, 24'h126000));
    send_item(cmd(bcwa_pkg::OP_SET_ALARM, 24'h235960));
    send_item(cmd(bcwa_pkg::OP_SET_TIME, 24'h235959));
    send_item(cmd(bcwa_pkg::OP_SET_ALARM, 24'h000000));
    send_item(cmd(bcwa_pkg::OP_ALARM_EN, '0, 1'b0));
    send_item(cmd(bcwa_pkg::OP_ALARM_EN, '0, 1'b1));
    send_item(cmd(bcwa_pkg::OP_SNOOZE, '0, 1'b0, 8'hFF));
    send_item(cmd(bcwa_pkg::OP_SNOOZE, '0, 1'b0, 8'h00));
    send_item(cmd(bcwa_pkg::OP_TICK));
    write_tps(32'd2);
    // wrap to midnight and hit the alarm
    send_item(cmd(bcwa_pkg::OP_TICK));
    send_item(cmd(bcwa_pkg::OP_SNOOZE, '0, 1'b0, 8'd1));
    send_item(cmd(bcwa_pkg::OP_SET_TIME, 24'h000059));
    repeat (2) send_item(cmd(bcwa_pkg::OP_TICK));
    send_item(cmd(bcwa_pkg::OP_ACK));
    send_item(cmd(bcwa_pkg::OP_SET_TIME, 24'h195959));
    repeat (2) send_item(cmd(bcwa_pkg::OP_TICK));
    send_item(cmd(bcwa_pkg::OP_SET_TIME, 24'h095959));
    repeat (2) send_item(cmd(bcwa_pkg::OP_TICK));
  endtask

  task automatic test_random_phases();
    int          tps_plan[8] = '{1, 2, 3, 1, 4, 1, 2, 7};
    logic [31:0] value;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 69; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 69; end
        default: begin send_idle_pct = 10; ready_stall_pct = 10; end
      endcase
      value = tps_plan[p];
      // keep the prescaler reachable from its current count
      if (value <= tick_count) value = tick_count + 32'd1;
      write_tps(value);
      repeat (145) send_item(random_item());
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    hold_left       = 300;
    repeat (80) send_item(random_item());
  endtask

  task automatic test_prescaler_extremes();
    send_idle_pct   = 10;
    ready_stall_pct = 10;
    write_tps(32'hFFFF_FFFF);
    repeat (20) send_item(random_item());
    write_tps(32'd0);
    repeat (20) send_item(random_item());
    write_tps(32'd1);
    repeat (20) send_item(random_item());
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = bcwa_pkg::OP_READ;
    in_ch.hour_tens      = '0;
    in_ch.hour_units     = '0;
    in_ch.minute_tens    = '0;
    in_ch.minute_units   = '0;
    in_ch.second_tens    = '0;
    in_ch.second_units   = '0;
    in_ch.enable_flag    = 1'b0;
    in_ch.snooze_minutes = '0;
    out_ch.ready         = 1'b0;
    now_digits           = '0;
    alarm_digits         = '0;
    time_set             = 1'b0;
    alarm_on             = 1'b0;
    alarm_latch          = 1'b0;
    snooze_left          = '0;
    tick_count           = '0;
    tps                  = bcwa_pkg::TPS_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phases();
    test_backpressure();
    test_prescaler_extremes();

    wait_idle();
    repeat (10) @(posedge clk);
    if (status_q.size() != 0) begin
      errors++;
      $display("%0t: %0d transactions expected, got none", $time, status_q.size());
    end
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
